// File: rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WBMP stream decoder: result kinds and
// the command that the parser hands to the pixel expander.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int PIX_PER_BYTE = 8;
   localparam int PIX_IDX_BITS = 3;
   localparam int OUT_BITS     = 16;
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_BITS   = 2;
   localparam int Q_CNT_BITS   = 3;

   typedef enum logic [2:0] {
      KIND_PIXEL     = 3'd0,
      KIND_SIZE      = 3'd1,
      KIND_ZERO_W    = 3'd2,
      KIND_ZERO_H    = 3'd3,
      KIND_TOO_LARGE = 3'd4,
      KIND_EXTRA     = 3'd5
   } kind_type;

   // One parsed command: a pixel byte or a single report.
   typedef struct packed {
      kind_type                  kind;
      logic [7:0]                data;
      logic [OUT_BITS-1:0]       col;
      logic [OUT_BITS-1:0]       row;
      logic [OUT_BITS-1:0]       width;
      logic [OUT_BITS-1:0]       height;
      logic [PIX_IDX_BITS-1:0]   last_idx;
   } cmd_type;

endpackage

// File: rtl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Byte parser: tracks the file phase, builds width and height, keeps the
// pixel position and issues one command per byte that produces results.
// ----------------------------------------------------------------------------
module wsd_front #(
   parameter int DIM_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_in_byte,
   input  logic             q_full,
   output logic             req_stall,
   output logic             push,
   output wsd_pkg::cmd_type push_cmd
);

   localparam int EXT_BITS = DIM_BITS + wsd_pkg::OUT_BITS;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_HEADER,
      PH_WIDTH,
      PH_HEIGHT,
      PH_PIXELS,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [DIM_BITS-1:0]    acc_ff, acc_in;
   logic [DIM_BITS-1:0]    width_ff, width_in;
   logic [DIM_BITS-1:0]    height_ff, height_in;
   logic [DIM_BITS-1:0]    col_ff, col_in;
   logic [DIM_BITS-1:0]    row_ff, row_in;

   logic                   accept;
   logic [DIM_BITS+6:0]    dim_next;
   logic                   dim_ovf;
   logic [DIM_BITS-1:0]    dim_val;
   logic [DIM_BITS:0]      col_sum;
   logic [DIM_BITS-1:0]    row_inc;
   logic [DIM_BITS-1:0]    rem;
   logic [EXT_BITS-1:0]    col_ext, row_ext, w_ext, h_ext;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign dim_next = {acc_ff, req_in_byte[6:0]};
   assign dim_ovf  = |dim_next[DIM_BITS+6:DIM_BITS];
   assign dim_val  = dim_next[DIM_BITS-1:0];
   assign col_sum  = {1'b0, col_ff} + (DIM_BITS+1)'(wsd_pkg::PIX_PER_BYTE);
   assign row_inc  = row_ff + DIM_BITS'(1);
   assign rem      = width_ff - col_ff;

   assign col_ext = EXT_BITS'(col_ff);
   assign row_ext = EXT_BITS'(row_ff);
   assign w_ext   = EXT_BITS'(width_ff);
   assign h_ext   = EXT_BITS'(dim_val);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      push      = 1'b0;
      push_cmd  = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_TYPE: begin
               phase_in = PH_HEADER;
            end
            PH_HEADER: begin
               if (!req_in_byte[7]) begin
                  phase_in = PH_WIDTH;
                  acc_in   = '0;
               end
            end
            PH_WIDTH: begin
               if (dim_ovf) begin
                  push          = 1'b1;
                  push_cmd.kind = wsd_pkg::KIND_TOO_LARGE;
                  phase_in      = PH_ERROR;
               end else if (req_in_byte[7]) begin
                  acc_in = dim_val;
               end else begin
                  width_in = dim_val;
                  acc_in   = '0;
                  if (dim_val == '0) begin
                     push          = 1'b1;
                     push_cmd.kind = wsd_pkg::KIND_ZERO_W;
                     phase_in      = PH_ERROR;
                  end else begin
                     phase_in = PH_HEIGHT;
                  end
               end
            end
            PH_HEIGHT: begin
               if (dim_ovf) begin
                  push          = 1'b1;
                  push_cmd.kind = wsd_pkg::KIND_TOO_LARGE;
                  phase_in      = PH_ERROR;
               end else if (req_in_byte[7]) begin
                  acc_in = dim_val;
               end else begin
                  height_in = dim_val;
                  acc_in    = '0;
                  push      = 1'b1;
                  if (dim_val == '0) begin
                     push_cmd.kind = wsd_pkg::KIND_ZERO_H;
                     phase_in      = PH_ERROR;
                  end else begin
                     push_cmd.kind   = wsd_pkg::KIND_SIZE;
                     push_cmd.width  = w_ext[wsd_pkg::OUT_BITS-1:0];
                     push_cmd.height = h_ext[wsd_pkg::OUT_BITS-1:0];
                     col_in          = '0;
                     row_in          = '0;
                     phase_in        = PH_PIXELS;
                  end
               end
            end
            PH_PIXELS: begin
               push          = 1'b1;
               push_cmd.kind = wsd_pkg::KIND_PIXEL;
               push_cmd.data = req_in_byte;
               push_cmd.col  = col_ext[wsd_pkg::OUT_BITS-1:0];
               push_cmd.row  = row_ext[wsd_pkg::OUT_BITS-1:0];
               if (rem >= DIM_BITS'(wsd_pkg::PIX_PER_BYTE)) begin
                  push_cmd.last_idx = wsd_pkg::PIX_IDX_BITS'(wsd_pkg::PIX_PER_BYTE - 1);
               end else begin
                  push_cmd.last_idx = rem[wsd_pkg::PIX_IDX_BITS-1:0]
                                      - wsd_pkg::PIX_IDX_BITS'(1);
               end
               if (col_sum >= {1'b0, width_ff}) begin
                  col_in = '0;
                  row_in = row_inc;
                  if (row_inc >= height_ff) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  col_in = col_sum[DIM_BITS-1:0];
               end
            end
            PH_DONE: begin
               push          = 1'b1;
               push_cmd.kind = wsd_pkg::KIND_EXTRA;
            end
            PH_ERROR: begin
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         acc_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// File: rtl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// Short command FIFO between the parser and the pixel expander.
// ----------------------------------------------------------------------------
module wsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wsd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output wsd_pkg::cmd_type head
);

   wsd_pkg::cmd_type                   mem_ff [wsd_pkg::Q_DEPTH];
   logic [wsd_pkg::Q_PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [wsd_pkg::Q_CNT_BITS-1:0]     count_ff;

   assign full  = (count_ff == wsd_pkg::Q_CNT_BITS'(wsd_pkg::Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + wsd_pkg::Q_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + wsd_pkg::Q_PTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + wsd_pkg::Q_CNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - wsd_pkg::Q_CNT_BITS'(1);
         end
      end
   end

endmodule

// File: rtl/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Pixel expander: walks the head command one result per cycle while the output
// is not stalled, MSB first, into the registered result stage.
// ----------------------------------------------------------------------------
module wsd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  wsd_pkg::cmd_type head,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_pixel_value,
   output logic [15:0]      rsp_column,
   output logic [15:0]      rsp_row,
   output logic [15:0]      rsp_image_width,
   output logic [15:0]      rsp_image_height,
   output logic             rsp_last_in_run
);

   logic [wsd_pkg::PIX_IDX_BITS-1:0] idx_ff;
   logic                             valid_ff;
   logic [2:0]                       kind_ff;
   logic [7:0]                       pix_ff;
   logic [15:0]                      col_ff, row_ff, w_ff, h_ff;
   logic                             last_ff;

   logic                             out_ready;
   logic                             fire;
   logic                             last;
   logic [wsd_pkg::PIX_IDX_BITS-1:0] bit_sel;

   assign out_ready = !valid_ff || !rsp_stall;
   assign fire      = out_ready && !q_empty;
   assign last      = (idx_ff == head.last_idx);
   assign pop       = fire && last;
   assign bit_sel   = wsd_pkg::PIX_IDX_BITS'(wsd_pkg::PIX_PER_BYTE - 1) - idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (out_ready) begin
            valid_ff <= !q_empty;
         end
         if (fire) begin
            idx_ff <= last ? '0 : idx_ff + wsd_pkg::PIX_IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff <= head.kind;
         pix_ff  <= head.data[bit_sel] ? 8'hFF : 8'h00;
         col_ff  <= head.col + 16'(idx_ff);
         row_ff  <= head.row;
         w_ff    <= head.width;
         h_ff    <= head.height;
         last_ff <= last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_pixel_value  = pix_ff;
   assign rsp_column       = col_ff;
   assign rsp_row          = row_ff;
   assign rsp_image_width  = w_ff;
   assign rsp_image_height = h_ff;
   assign rsp_last_in_run  = last_ff;

endmodule

// File: rtl/wbmp_stream_decoder.sv
// A byte's first result passes the command queue and then the registered result
// stage before it shows on rsp_valid.
// Throughput: one byte per cycle into the parser while the queue is not full;
// one result per cycle out of the expander while rsp_stall does not hold it.
// A 4-deep command queue lets the parser run ahead of the expander.
// Reset (synchronous, active high) returns to the type byte and empties the queue.
// ----------------------------------------------------------------------------
// wbmp_stream_decoder
// Streaming decoder for type 0 WBMP files: parser, command queue, and
// pixel expander with a registered result stage.
// ----------------------------------------------------------------------------
module wbmp_stream_decoder #(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_pixel_value,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_row,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic        rsp_last_in_run
);

   logic             q_full, q_empty, push, pop;
   wsd_pkg::cmd_type push_cmd, head;

   wsd_front #(
      .DIM_BITS(DIM_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   wsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   wsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .head             (head),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_last_in_run  (rsp_last_in_run)
   );

endmodule

// File: tb/wbmp_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// wbmp_stream_decoder_tb
// Streams one WBMP file into the decoder and checks every result beat
// against an in-bench model of the parser and the pixel expander. Most seeds
// send a full image: type, skipped header bytes, multi-byte width and height,
// random pixel rows, then trailing data. A few seeds end the header in a zero
// width, a zero height or an oversized dimension instead, and follow it with
// bytes that must be ignored. Both handshakes see random stall and gap bursts.
// ----------------------------------------------------------------------------
module wbmp_stream_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DIM_MAX     = 16'hFFFF;
   localparam int MIN_BYTES   = 150;

   localparam int DIM_MORE     = 0;
   localparam int DIM_DONE     = 1;
   localparam int DIM_OVERFLOW = 2;

   localparam int SCEN_ZERO_W   = 0;
   localparam int SCEN_ZERO_H   = 1;
   localparam int SCEN_BIG_W    = 2;
   localparam int SCEN_BIG_H    = 3;
   localparam int SCEN_IMAGE    = 4;

   typedef enum logic [2:0] {
      AWAIT_TYPE, IN_HEADER, IN_WIDTH, IN_HEIGHT, IN_PIXELS, IMAGE_DONE, HALTED
   } parse_phase_type;

   typedef struct packed {
      wsd_pkg::kind_type kind;
      logic [7:0]        pixel_value;
      logic [15:0]       column;
      logic [15:0]       row;
      logic [15:0]       image_width;
      logic [15:0]       image_height;
      logic              last_in_run;
   } decoded_result_type;

   class wbmp_scoreboard;
      parse_phase_type    phase;
      logic [7:0]         image_type;
      int                 dim_acc;
      int                 width;
      int                 height;
      int                 col_pos;
      int                 row_pos;
      decoded_result_type expected_q[$];
      int                 errors;
      int                 checked;

      function new();
         phase      = AWAIT_TYPE;
         image_type = 8'd0;
         dim_acc    = 0;
         width      = 0;
         height     = 0;
         col_pos    = 0;
         row_pos    = 0;
         errors     = 0;
         checked    = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void push_result(wsd_pkg::kind_type k, logic [7:0] pv, int c, int r,
                                int w, int h);
         decoded_result_type e;
         e.kind         = k;
         e.pixel_value  = pv;
         e.column       = 16'(c);
         e.row          = 16'(r);
         e.image_width  = 16'(w);
         e.image_height = 16'(h);
         e.last_in_run  = 1'b0;
         expected_q.push_back(e);
      endfunction

      function int add_dim_group(logic [7:0] b);
         int grown;
         grown = (dim_acc << 7) | int'(b[6:0]);
         if (grown > DIM_MAX) return DIM_OVERFLOW;
         dim_acc = grown;
         return b[7] ? DIM_MORE : DIM_DONE;
      endfunction

      // Runs one accepted input beat through the model.
      function void note_byte(logic [7:0] b);
         int depth_at_entry;
         int grade;
         int x;
         depth_at_entry = expected_q.size();
         case (phase)
            AWAIT_TYPE: begin
               image_type = b;
               phase      = IN_HEADER;
            end
            IN_HEADER: begin
               if (!b[7]) begin
                  phase   = IN_WIDTH;
                  dim_acc = 0;
               end
            end
            IN_WIDTH, IN_HEIGHT: begin
               grade = add_dim_group(b);
               if (grade == DIM_OVERFLOW) begin
                  push_result(wsd_pkg::KIND_TOO_LARGE, 8'd0, 0, 0, 0, 0);
                  phase = HALTED;
               end else if (grade == DIM_DONE && phase == IN_WIDTH) begin
                  width   = dim_acc;
                  dim_acc = 0;
                  if (width == 0) begin
                     push_result(wsd_pkg::KIND_ZERO_W, 8'd0, 0, 0, 0, 0);
                     phase = HALTED;
                  end else begin
                     phase = IN_HEIGHT;
                  end
               end else if (grade == DIM_DONE) begin
                  height  = dim_acc;
                  dim_acc = 0;
                  if (height == 0) begin
                     push_result(wsd_pkg::KIND_ZERO_H, 8'd0, 0, 0, 0, 0);
                     phase = HALTED;
                  end else begin
                     push_result(wsd_pkg::KIND_SIZE, 8'd0, 0, 0, width, height);
                     col_pos = 0;
                     row_pos = 0;
                     phase   = IN_PIXELS;
                  end
               end
            end
            IN_PIXELS: begin
               for (int i = 0; i < wsd_pkg::PIX_PER_BYTE; i++) begin
                  x = col_pos + i;
                  if (x < width)
                     push_result(wsd_pkg::KIND_PIXEL, b[7-i] ? 8'hFF : 8'h00, x, row_pos,
                                 0, 0);
               end
               if (col_pos + wsd_pkg::PIX_PER_BYTE >= width) begin
                  col_pos = 0;
                  row_pos++;
                  if (row_pos >= height) phase = IMAGE_DONE;
               end else begin
                  col_pos += wsd_pkg::PIX_PER_BYTE;
               end
            end
            IMAGE_DONE: push_result(wsd_pkg::KIND_EXTRA, 8'd0, 0, 0, 0, 0);
            default: ;
         endcase
         if (expected_q.size() > depth_at_entry)
            expected_q[expected_q.size()-1].last_in_run = 1'b1;
      endfunction

      function void report(string field, int exp_val, int act_val);
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
      endfunction

      function void check_result(decoded_result_type got);
         decoded_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result beat, kind %0d", $time, got.kind);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (got.kind != e.kind) report("kind", e.kind, got.kind);
         if (got.pixel_value != e.pixel_value)
            report("pixel_value", e.pixel_value, got.pixel_value);
         if (got.column != e.column) report("column", e.column, got.column);
         if (got.row != e.row) report("row", e.row, got.row);
         if (got.image_width != e.image_width)
            report("image_width", e.image_width, got.image_width);
         if (got.image_height != e.image_height)
            report("image_height", e.image_height, got.image_height);
         if (got.last_in_run != e.last_in_run)
            report("last_in_run", e.last_in_run, got.last_in_run);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_pixel_value;
   logic [15:0] rsp_column;
   logic [15:0] rsp_row;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic        rsp_last_in_run;

   wbmp_scoreboard sb = new();
   logic [7:0]     stream_q[$];
   bit             calm = 1'b0;
   int             stall_left = 0;
   int             cycle_count = 0;
   int             scenario;
   int             pause_at;
   int             calm_from;
   int             img_w;
   int             img_h;
   int             row_bytes;
   int             first_pixel;

   wbmp_stream_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_last_in_run  (rsp_last_in_run)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
         $display("wbmp_stream_decoder test failed");
         $finish;
      end
   end

   // Result side: check accepted beats, then pick the stall for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{kind: wsd_pkg::kind_type'(rsp_kind),
                           pixel_value: rsp_pixel_value,
                           column: rsp_column, row: rsp_row,
                           image_width: rsp_image_width,
                           image_height: rsp_image_height,
                           last_in_run: rsp_last_in_run});
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Dimension as three 7-bit groups, the first one a zero continuation.
   task automatic push_dim(input int v);
      stream_q.push_back(8'h80);
      stream_q.push_back(8'h80 | 8'((v >> 7) & 8'h7F));
      stream_q.push_back(8'(v & 8'h7F));
   endtask

   task automatic build_stream();
      stream_q.push_back(8'($urandom_range(0, 255)));
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h80);
      repeat ($urandom_range(0, 3)) stream_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
      stream_q.push_back(8'($urandom_range(0, 127)));
      scenario = $urandom_range(0, 11);
      if (scenario > SCEN_IMAGE) scenario = SCEN_IMAGE;
      case (scenario)
         SCEN_ZERO_W: begin
            stream_q.push_back(8'h80);
            stream_q.push_back(8'h00);
         end
         SCEN_ZERO_H: begin
            push_dim($urandom_range(1, 127));
            stream_q.push_back(8'h80);
            stream_q.push_back(8'h00);
         end
         SCEN_BIG_W: begin
            stream_q.push_back(8'h84);
            stream_q.push_back(8'h80);
            stream_q.push_back(8'h80);
         end
         SCEN_BIG_H: begin
            push_dim($urandom_range(1, 40));
            stream_q.push_back(8'h83);
            stream_q.push_back(8'hFF);
            stream_q.push_back(8'hFF);
            stream_q.push_back(8'h80);
         end
         default: begin
            case ($urandom_range(0, 3))
               0: img_w = 1;
               1: img_w = 8;
               default: img_w = $urandom_range(9, 200);
            endcase
            row_bytes = (img_w + 7) / 8;
            img_h = 130 / row_bytes;
            if (img_h < 1) img_h = 1;
            push_dim(img_w);
            push_dim(img_h);
            first_pixel = stream_q.size();
            stream_q.push_back(8'h00);
            stream_q.push_back(8'hFF);
            stream_q.push_back(8'h80);
            stream_q.push_back(8'h01);
            while (stream_q.size() < first_pixel + row_bytes * img_h)
               stream_q.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      pause_at = (scenario == SCEN_IMAGE) ? first_pixel + (row_bytes * img_h) / 2
                                          : stream_q.size();
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      repeat (14) stream_q.push_back(8'($urandom_range(0, 255)));
      while (stream_q.size() < MIN_BYTES)
         stream_q.push_back(8'($urandom_range(0, 255)));
      calm_from = (stream_q.size() * 3) / 4;
   endtask

   initial begin
      img_w = 0;
      img_h = 0;
      row_bytes = 1;
      first_pixel = 0;
      build_stream();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < stream_q.size(); i++) begin
         if (i == pause_at) drain();
         calm = (i >= calm_from);
         send_byte(stream_q[i]);
      end
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes (scenario %0d, image %0dx%0d); %0d result beats checked.",
               stream_q.size(), scenario, img_w, img_h, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("wbmp_stream_decoder test passed");
      end else begin
         $display("wbmp_stream_decoder test failed");
      end
      $finish;
   end

endmodule
